>>> rtl/core/irss_pkg.sv
package irss_pkg;

    // action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_READ_ONE = 2'd1;
    localparam logic [1:0] ACT_READ_ALL = 2'd2;
    // action code the block ignores
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    // scan phase codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LR   = 3'd1;
    localparam logic [2:0] PH_LF   = 3'd2;
    localparam logic [2:0] PH_RF   = 3'd3;
    localparam logic [2:0] PH_RR   = 3'd4;

    // sensor indices
    localparam logic [1:0] SNS_LF = 2'd0;
    localparam logic [1:0] SNS_LR = 2'd1;
    localparam logic [1:0] SNS_RR = 2'd2;
    localparam logic [1:0] SNS_RF = 2'd3;

    // configuration register indices
    localparam logic [2:0] REG_LIMIT_LF = 3'd0;
    localparam logic [2:0] REG_LIMIT_LR = 3'd1;
    localparam logic [2:0] REG_LIMIT_RR = 3'd2;
    localparam logic [2:0] REG_LIMIT_RF = 3'd3;
    localparam logic [2:0] REG_IDLE     = 3'd4;
    localparam logic [2:0] REG_ON       = 3'd5;

    // reset values
    localparam logic [7:0] LIMIT_RST     = 8'd240;
    localparam logic [7:0] IDLE_WAIT_RST = 8'd30;
    localparam logic [7:0] ON_TICKS_RST  = 8'd5;

    localparam logic [1:0] LAST_SENSOR = 2'd3;

    typedef struct packed {
        logic [3:0][7:0] limit;
        logic [7:0]      idle_wait_ticks;
        logic [7:0]      emitter_on_ticks;
    } cfg_t;

    // one queued transaction snapshot, one or four result beats
    typedef struct packed {
        logic [3:0]      emitter_mask;
        logic            sample_stored;
        logic [3:0]      near_flags;
        logic [3:0][7:0] vals;
        logic [1:0]      index;
        logic            multi;
    } entry_t;

    // emitter lit in a given phase
    function automatic logic [3:0] lit_mask(input logic [2:0] ph);
        logic [3:0] m;
        begin
            case (ph)
                PH_LR:   m = 4'b0010;
                PH_LF:   m = 4'b0001;
                PH_RF:   m = 4'b1000;
                PH_RR:   m = 4'b0100;
                default: m = 4'b0000;
            endcase
            return m;
        end
    endfunction

endpackage

>>> rtl/core/irss_cfg.sv
module irss_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_wdata,
    output irss_pkg::cfg_t      cfg
);

    irss_pkg::cfg_t cfg_reg;

    // register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit            <= {4{irss_pkg::LIMIT_RST}};
            cfg_reg.idle_wait_ticks  <= irss_pkg::IDLE_WAIT_RST;
            cfg_reg.emitter_on_ticks <= irss_pkg::ON_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                irss_pkg::REG_LIMIT_LF: cfg_reg.limit[irss_pkg::SNS_LF] <= cfg_wdata;
                irss_pkg::REG_LIMIT_LR: cfg_reg.limit[irss_pkg::SNS_LR] <= cfg_wdata;
                irss_pkg::REG_LIMIT_RR: cfg_reg.limit[irss_pkg::SNS_RR] <= cfg_wdata;
                irss_pkg::REG_LIMIT_RF: cfg_reg.limit[irss_pkg::SNS_RF] <= cfg_wdata;
                irss_pkg::REG_IDLE:     cfg_reg.idle_wait_ticks  <= cfg_wdata;
                irss_pkg::REG_ON:       cfg_reg.emitter_on_ticks <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/irss_scan.sv
module irss_scan
(
    input  logic                clk,
    input  logic                rst_n,
    input  irss_pkg::cfg_t      cfg,
    input  logic                accept,
    input  logic [1:0]          action,
    input  logic [7:0]          adc_sample,
    input  logic [7:0]          query_sensor,
    output logic                push,
    output irss_pkg::entry_t    entry
);

    logic [2:0]      phase_reg, phase_next;
    logic [7:0]      count_reg, count_next;
    logic [3:0][7:0] ranges_reg, ranges_next;
    logic [3:0]      near_reg, near_next;

    // sequencer next state and result snapshot
    always_comb
    begin
        logic [7:0] dec;
        logic       take;
        logic [1:0] sns;
        logic [1:0] q;
        dec         = count_reg - 8'd1;
        take        = 1'b0;
        sns         = irss_pkg::SNS_LF;
        q           = (query_sensor > 8'd3) ? irss_pkg::SNS_LF : query_sensor[1:0];
        phase_next  = phase_reg;
        count_next  = count_reg;
        ranges_next = ranges_reg;
        near_next   = near_reg;

        if (action == irss_pkg::ACT_TICK)
        begin
            count_next = dec;
            if (dec == 8'd0)
            begin
                count_next = cfg.emitter_on_ticks;
                case (phase_reg)
                    irss_pkg::PH_LR:
                    begin
                        take       = 1'b1;
                        sns        = irss_pkg::SNS_LR;
                        phase_next = irss_pkg::PH_LF;
                    end
                    irss_pkg::PH_LF:
                    begin
                        take       = 1'b1;
                        sns        = irss_pkg::SNS_LF;
                        phase_next = irss_pkg::PH_RF;
                    end
                    irss_pkg::PH_RF:
                    begin
                        take       = 1'b1;
                        sns        = irss_pkg::SNS_RF;
                        phase_next = irss_pkg::PH_RR;
                    end
                    irss_pkg::PH_RR:
                    begin
                        take       = 1'b1;
                        sns        = irss_pkg::SNS_RR;
                        phase_next = irss_pkg::PH_IDLE;
                        count_next = cfg.idle_wait_ticks;
                    end
                    default:
                    begin
                        phase_next = irss_pkg::PH_LR;
                    end
                endcase
            end
        end

        // store sample and refresh that sensor's near flag
        if (take)
        begin
            ranges_next[sns] = adc_sample;
            near_next[sns]   = adc_sample > cfg.limit[sns];
        end

        push                = (action != irss_pkg::ACT_UNUSED) && accept;
        entry.emitter_mask  = irss_pkg::lit_mask(phase_next);
        entry.sample_stored = take;
        entry.near_flags    = near_next;
        entry.vals          = '0;
        entry.index         = irss_pkg::SNS_LF;
        entry.multi         = 1'b0;
        case (action)
            irss_pkg::ACT_READ_ONE:
            begin
                entry.vals[0] = ranges_reg[q];
                entry.index   = q;
            end
            irss_pkg::ACT_READ_ALL:
            begin
                entry.vals  = ranges_reg;
                entry.multi = 1'b1;
            end
            default: ;
        endcase
    end

    // state update on accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= irss_pkg::PH_IDLE;
            count_reg  <= irss_pkg::IDLE_WAIT_RST;
            ranges_reg <= '0;
            near_reg   <= '0;
        end
        else if (push)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            ranges_reg <= ranges_next;
            near_reg   <= near_next;
        end
    end

endmodule

>>> rtl/core/irss_outq.sv
module irss_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  irss_pkg::entry_t    entry,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          emitter_mask,
    output logic                sample_stored,
    output logic [3:0]          near_flags,
    output logic [7:0]          range_value,
    output logic [1:0]          range_index,
    output logic                last_of_run
);

    irss_pkg::entry_t slot0_reg, slot1_reg;
    logic [1:0]       count_reg;
    logic [1:0]       beat_reg;
    logic             head_last;
    logic             fire;
    logic             pop;

    // head beat decode
    assign head_last = beat_reg == (slot0_reg.multi ? irss_pkg::LAST_SENSOR : 2'd0);
    assign out_valid = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;
    assign fire      = out_valid && !out_stall;
    assign pop       = fire && head_last;

    assign emitter_mask  = slot0_reg.emitter_mask;
    assign sample_stored = slot0_reg.sample_stored;
    assign near_flags    = slot0_reg.near_flags;
    assign range_value   = slot0_reg.vals[beat_reg];
    assign range_index   = slot0_reg.multi ? beat_reg : slot0_reg.index;
    assign last_of_run   = head_last;

    // two-slot snapshot queue, head always in slot0
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && (count_reg == 2'd1))
                slot0_reg <= entry;
            else
                slot0_reg <= slot1_reg;
            if (push)
                slot1_reg <= entry;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                slot0_reg <= entry;
            else
                slot1_reg <= entry;
        end
    end

    // occupancy and beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            beat_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (fire)
                beat_reg <= head_last ? 2'd0 : beat_reg + 2'd1;
        end
    end

endmodule

>>> rtl/core/ir_range_sensor_scan_sequencer_top.sv
// results of a transaction are registered in the snapshot queue before they appear
// one input transaction per cycle while the queue is not full; a read-all drives four
// result beats, so the output side limits the rate for such reads
// a two-slot snapshot queue sits between input and output handshakes
// reset (rst_n low, asynchronous) restores register defaults, idle phase,
// countdown 30, zero ranges and near flags, and empties the queue
module ir_range_sensor_scan_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  adc_sample,
    input  logic [7:0]  query_sensor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  emitter_mask,
    output logic        sample_stored,
    output logic [3:0]  near_flags,
    output logic [7:0]  range_value,
    output logic [1:0]  range_index,
    output logic        last_of_run
);

    irss_pkg::cfg_t   cfg;
    irss_pkg::entry_t entry;
    logic             push;
    logic             full;
    logic             accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // configuration registers
    irss_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // scan sequencer state
    irss_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .accept       (accept),
        .action       (action),
        .adc_sample   (adc_sample),
        .query_sensor (query_sensor),
        .push         (push),
        .entry        (entry)
    );

    // result queue and beat sequencing
    irss_outq u_outq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .entry         (entry),
        .full          (full),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .emitter_mask  (emitter_mask),
        .sample_stored (sample_stored),
        .near_flags    (near_flags),
        .range_value   (range_value),
        .range_index   (range_index),
        .last_of_run   (last_of_run)
    );

endmodule

>>> tb/scan_result_checker.sv
`timescale 1ns / 100ps

module scan_result_checker
    import irss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  adc_sample,
    input  logic [7:0]  query_sensor,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  emitter_mask,
    input  logic        sample_stored,
    input  logic [3:0]  near_flags,
    input  logic [7:0]  range_value,
    input  logic [1:0]  range_index,
    input  logic        last_of_run,
    output int          fail_count,
    output int          reports_due
);

    // one result beat as the block should present it
    typedef struct {
        logic [3:0] mask;
        logic       stored;
        logic [3:0] near;
        logic [7:0] value;
        logic [1:0] index;
        logic       last;
    } report_t;

    report_t    due_q[$];
    int         errs = 0;

    // shadow copy of the registers and the scan state
    logic [7:0] limits [4];
    logic [7:0] idle_ticks;
    logic [7:0] on_ticks;
    logic [2:0] scan_ph;
    logic [7:0] countdown;
    logic [7:0] ranges [4];
    logic [3:0] near;

    // emitter powered while in a given scan phase
    function automatic logic [3:0] emitter_for_phase(input logic [2:0] ph);
        logic [3:0] m;
        begin
            m = 4'b0000;
            if (ph == PH_LR)
                m[SNS_LR] = 1'b1;
            else if (ph == PH_LF)
                m[SNS_LF] = 1'b1;
            else if (ph == PH_RF)
                m[SNS_RF] = 1'b1;
            else if (ph == PH_RR)
                m[SNS_RR] = 1'b1;
            return m;
        end
    endfunction

    // latch a range and refresh that sensor's near flag
    task automatic store_range(input logic [1:0] s, input logic [7:0] adc);
        begin
            ranges[s] = adc;
            near[s] = (adc > limits[s]);
        end
    endtask

    // advance the scan for one transaction and queue the beats it causes
    task automatic scan_step(input logic [1:0] act, input logic [7:0] adc,
                             input logic [7:0] q);
        report_t    r;
        logic [1:0] sel;
        begin
            r = '{mask: 4'd0, stored: 1'b0, near: 4'd0, value: 8'd0, index: 2'd0,
                  last: 1'b1};
            case (act)
                ACT_TICK:
                begin
                    countdown = countdown - 8'd1;
                    if (countdown == 8'd0)
                    begin
                        case (scan_ph)
                            PH_LR:
                            begin
                                store_range(SNS_LR, adc);
                                scan_ph = PH_LF;
                                countdown = on_ticks;
                            end
                            PH_LF:
                            begin
                                store_range(SNS_LF, adc);
                                scan_ph = PH_RF;
                                countdown = on_ticks;
                            end
                            PH_RF:
                            begin
                                store_range(SNS_RF, adc);
                                scan_ph = PH_RR;
                                countdown = on_ticks;
                            end
                            PH_RR:
                            begin
                                store_range(SNS_RR, adc);
                                scan_ph = PH_IDLE;
                                countdown = idle_ticks;
                            end
                            default:
                            begin
                                scan_ph = PH_LR;
                                countdown = on_ticks;
                            end
                        endcase
                        r.stored = (scan_ph != PH_LR);
                    end
                    r.mask = emitter_for_phase(scan_ph);
                    r.near = near;
                    due_q.push_back(r);
                end
                ACT_READ_ONE:
                begin
                    sel = (q > LAST_SENSOR) ? SNS_LF : q[1:0];
                    r.mask = emitter_for_phase(scan_ph);
                    r.near = near;
                    r.value = ranges[sel];
                    r.index = sel;
                    due_q.push_back(r);
                end
                ACT_READ_ALL:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        r.mask = emitter_for_phase(scan_ph);
                        r.near = near;
                        r.value = ranges[i];
                        r.index = 2'(i);
                        r.last = (i == 3);
                        due_q.push_back(r);
                    end
                end
                default:
                    ;
            endcase
        end
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        begin
            if (want != got)
            begin
                errs++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, fname, want, got);
            end
        end
    endtask

    // predict on accepted inputs, compare accepted outputs in order
    always @(posedge clk or negedge rst_n)
    begin
        report_t r;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                limits[i] = LIMIT_RST;
                ranges[i] = 8'd0;
            end
            idle_ticks = IDLE_WAIT_RST;
            on_ticks = ON_TICKS_RST;
            scan_ph = PH_IDLE;
            countdown = IDLE_WAIT_RST;
            near = 4'd0;
            due_q.delete();
            fail_count <= errs;
            reports_due <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LIMIT_LF, REG_LIMIT_LR, REG_LIMIT_RR, REG_LIMIT_RF:
                        limits[cfg_index[1:0]] = cfg_wdata;
                    REG_IDLE:
                        idle_ticks = cfg_wdata;
                    REG_ON:
                        on_ticks = cfg_wdata;
                    default:
                        ;
                endcase
            end

            if (in_valid && !in_stall)
                scan_step(action, adc_sample, query_sensor);

            if (out_valid && !out_stall)
            begin
                if (due_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result, expected none, actual range_value %0d",
                             $time, range_value);
                end
                else
                begin
                    r = due_q.pop_front();
                    check_field("emitter_mask", r.mask, emitter_mask);
                    check_field("sample_stored", r.stored, sample_stored);
                    check_field("near_flags", r.near, near_flags);
                    check_field("range_value", r.value, range_value);
                    check_field("range_index", r.index, range_index);
                    check_field("last_of_run", r.last, last_of_run);
                end
            end

            fail_count <= errs;
            reports_due <= due_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import irss_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [7:0]  adc_sample;
    logic [7:0]  query_sensor;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  emitter_mask;
    logic        sample_stored;
    logic [3:0]  near_flags;
    logic [7:0]  range_value;
    logic [1:0]  range_index;
    logic        last_of_run;

    int          fail_count;
    int          reports_due;
    logic        idle_on;
    logic        rx_stall;
    logic        hold_stall;
    event        hold_off_ev;

    assign out_stall = rx_stall | hold_stall;

    ir_range_sensor_scan_sequencer_top dut (.*);

    scan_result_checker chk (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver stalls in random bursts
    initial
    begin
        rx_stall = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 20)) @(negedge clk);
            if (idle_on)
            begin
                rx_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                rx_stall <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        hold_stall = 1'b0;
        @(hold_off_ev);
        @(negedge clk);
        hold_stall <= 1'b1;
        repeat (60) @(negedge clk);
        hold_stall <= 1'b0;
    end

    // offer one transaction and wait for it to be taken
    task automatic send_item(input logic [1:0] act, input logic [7:0] adc,
                             input logic [7:0] q);
        begin
            @(negedge clk);
            in_valid <= 1'b1;
            action <= act;
            adc_sample <= adc;
            query_sensor <= q;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int cycles);
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
        end
    endtask

    // stop offering and wait until every expected beat has come out
    task automatic drain_reports();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
            while (reports_due != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // random mix, tick_pct percent ticks, the rest mostly reads
    task automatic run_random(input int count, input int tick_pct);
        int         roll;
        logic [1:0] act;
        logic [7:0] adc;
        logic [7:0] q;
        begin
            for (int k = 0; k < count; k++)
            begin
                roll = $urandom_range(99);
                if (roll < tick_pct)
                    act = ACT_TICK;
                else if (roll < tick_pct + (100 - tick_pct) / 2)
                    act = ACT_READ_ONE;
                else if (roll < 98)
                    act = ACT_READ_ALL;
                else
                    act = ACT_UNUSED;
                if ($urandom_range(7) == 0)
                    adc = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    adc = 8'($urandom);
                q = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
                send_item(act, adc, q);
                if (idle_on && $urandom_range(3) == 0)
                    idle_gap($urandom_range(1, 12));
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_LIMIT_LF;
        cfg_wdata = 8'd0;
        in_valid = 1'b0;
        action = ACT_TICK;
        adc_sample = 8'd0;
        query_sensor = 8'd0;
        idle_on = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reads at reset values, out-of-range queries, ignored action
        send_item(ACT_READ_ALL, 8'h00, 8'h00);
        send_item(ACT_READ_ONE, 8'h00, 8'(SNS_LF));
        send_item(ACT_READ_ONE, 8'h00, 8'(SNS_LR));
        send_item(ACT_READ_ONE, 8'h00, 8'(SNS_RR));
        send_item(ACT_READ_ONE, 8'h00, 8'(SNS_RF));
        send_item(ACT_READ_ONE, 8'h00, 8'd4);
        send_item(ACT_READ_ONE, 8'hFF, 8'hFF);
        send_item(ACT_UNUSED, 8'hFF, 8'hFF);
        run_random(10, 85);
        drain_reports();

        // thresholds at both extremes, fastest scan
        write_reg(REG_LIMIT_LF, 8'd0);
        write_reg(REG_LIMIT_LR, 8'd255);
        write_reg(REG_LIMIT_RR, 8'd0);
        write_reg(REG_LIMIT_RF, 8'd255);
        write_reg(REG_IDLE, 8'd1);
        write_reg(REG_ON, 8'd1);
        for (int k = 0; k < 12; k++)
            send_item(ACT_TICK, (k % 2) ? 8'hFF : 8'(k / 2), 8'h00);
        send_item(ACT_READ_ALL, 8'h00, 8'h00);
        run_random(20, 80);
        drain_reports();

        // random thresholds, read-heavy while the receiver holds off
        write_reg(REG_LIMIT_LF, 8'($urandom));
        write_reg(REG_LIMIT_LR, 8'($urandom));
        write_reg(REG_LIMIT_RR, 8'($urandom));
        write_reg(REG_LIMIT_RF, 8'($urandom));
        write_reg(REG_IDLE, 8'd2);
        write_reg(REG_ON, 8'd3);
        -> hold_off_ev;
        run_random(30, 50);
        drain_reports();

        // idle wait of zero wraps to a 256 tick wait
        write_reg(REG_LIMIT_LF, 8'd255);
        write_reg(REG_LIMIT_RR, 8'd128);
        write_reg(REG_IDLE, 8'd0);
        write_reg(REG_ON, 8'd1);
        run_random(270, 100);
        drain_reports();

        // slowest settings, no idling to the end
        write_reg(REG_LIMIT_LR, 8'($urandom));
        write_reg(REG_LIMIT_RF, 8'($urandom));
        write_reg(REG_IDLE, 8'd255);
        write_reg(REG_ON, 8'd255);
        idle_on = 1'b0;
        run_random(20, 50);
        drain_reports();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && reports_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
